// ===== src/signed_decimal_field_formatter_macros.svh =====
// Assertion macros used by the formatter controller.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDFF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdff: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdff: next-cycle check failed");

`endif

// ===== src/sdff_pkg.sv =====
// Types and constants shared by the signed decimal field formatter.
package sdff_pkg;

    localparam int VALUE_W  = 64;
    localparam int NDIGITS  = 20;
    localparam int BCD_W    = 4 * NDIGITS;
    localparam int FW_W     = 7;
    localparam int PREC_W   = 6;
    localparam int DCNT_W   = 5;
    localparam int STEP_W   = 6;
    localparam int CIDX_W   = 4;
    localparam int CDATA_W  = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        LEN_CHAR  = 2'd0,
        LEN_SHORT = 2'd1,
        LEN_INT   = 2'd2,
        LEN_LONG  = 2'd3
    } len_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LENGTH_MODE   = 4'd0,
        CFG_LEFT_JUSTIFY  = 4'd1,
        CFG_FORCE_PLUS    = 4'd2,
        CFG_SPACE_SIGN    = 4'd3,
        CFG_ZERO_PAD      = 4'd4,
        CFG_HAS_PRECISION = 4'd5,
        CFG_PRECISION     = 4'd6,
        CFG_FIELD_WIDTH   = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        len_t              length_mode;
        logic              left_justify;
        logic              force_plus;
        logic              space_sign;
        logic              zero_pad;
        logic              has_precision;
        logic [PREC_W-1:0] precision;
        logic [FW_W-1:0]   field_width;
    } cfg_t;

    typedef enum logic [1:0] {
        SRC_SPACE = 2'd0,
        SRC_SIGN  = 2'd1,
        SRC_ZERO  = 2'd2,
        SRC_DIGIT = 2'd3
    } src_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic scan;
        logic plan;
        logic emit;
        src_t src;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic scan_more;
        logic pad_zero;
        logic zeros_zero;
        logic dig_zero;
        logic has_sign;
        logic last;
    } sts_t;

endpackage

// ===== src/sdff_datapath.sv =====
// Datapath: operand extension, shift-add-3 conversion, field planning, character output.
module sdff_datapath #(
    parameter int MAX_FIELD = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sdff_pkg::cfg_t                     cfg,
    input  logic signed [sdff_pkg::VALUE_W-1:0] value,
    input  sdff_pkg::cmd_t                     cmd,
    output sdff_pkg::sts_t                     sts,
    output logic [7:0]                         out_char,
    output logic                               last_char
);

    localparam int CW = $clog2(MAX_FIELD + 1);
    localparam logic [sdff_pkg::FW_W-1:0] MAX_W = sdff_pkg::FW_W'(MAX_FIELD);

    logic [sdff_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [sdff_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [sdff_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [sdff_pkg::DCNT_W-1:0]  dc_reg, dc_next;
    logic [7:0]                   sign_ch_reg, sign_ch_next;
    logic                         sign_len_reg, sign_len_next;
    logic [CW-1:0]                pad_reg, pad_next;
    logic [CW-1:0]                zero_reg, zero_next;
    logic [CW-1:0]                tot_reg, tot_next;
    logic [7:0]                   out_char_reg, out_char_next;
    logic                         last_reg, last_next;

    logic [sdff_pkg::VALUE_W-1:0] ext;
    logic [sdff_pkg::BCD_W-1:0]   adj;
    logic [3:0]                   top_nib;
    logic                         no_digits;
    logic [sdff_pkg::DCNT_W-1:0]  dc_eff;
    logic [sdff_pkg::FW_W-1:0]    sl7, w7, p7, cap7, pc7, dc7, z7, body7, pad7, tot7;
    logic [7:0]                   emit_ch;

    assign top_nib = bcd_reg[sdff_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        unique case (cfg.length_mode)
            sdff_pkg::LEN_CHAR:  ext = {{56{value[7]}}, value[7:0]};
            sdff_pkg::LEN_SHORT: ext = {{48{value[15]}}, value[15:0]};
            sdff_pkg::LEN_INT:   ext = {{32{value[31]}}, value[31:0]};
            default:             ext = value;
        endcase
    end

    // Add 3 to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < sdff_pkg::NDIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Field layout, all in field-width arithmetic.
    always_comb
    begin
        no_digits = cfg.has_precision && (cfg.precision == '0) &&
                    (dc_reg == sdff_pkg::DCNT_W'(1)) && (top_nib == 4'd0);
        dc_eff = no_digits ? '0 : dc_reg;
        sl7  = {{(sdff_pkg::FW_W-1){1'b0}}, sign_len_reg};
        w7   = (cfg.field_width > MAX_W) ? MAX_W : cfg.field_width;
        if (cfg.has_precision)
            p7 = {{(sdff_pkg::FW_W-sdff_pkg::PREC_W){1'b0}}, cfg.precision};
        else if (cfg.zero_pad)
            p7 = (w7 > sl7) ? (w7 - sl7) : '0;
        else
            p7 = '0;
        cap7  = MAX_W - sl7;
        pc7   = (p7 > cap7) ? cap7 : p7;
        dc7   = {{(sdff_pkg::FW_W-sdff_pkg::DCNT_W){1'b0}}, dc_eff};
        z7    = (pc7 > dc7) ? (pc7 - dc7) : '0;
        body7 = sl7 + z7 + dc7;
        pad7  = (w7 > body7) ? (w7 - body7) : '0;
        tot7  = body7 + pad7;
    end

    always_comb
    begin
        case (cmd.src)
            sdff_pkg::SRC_SPACE: emit_ch = sdff_pkg::CH_SPACE;
            sdff_pkg::SRC_SIGN:  emit_ch = sign_ch_reg;
            sdff_pkg::SRC_ZERO:  emit_ch = sdff_pkg::CH_ZERO;
            default:             emit_ch = sdff_pkg::CH_ZERO + {4'd0, top_nib};
        endcase
    end

    always_comb
    begin
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        step_next     = step_reg;
        dc_next       = dc_reg;
        sign_ch_next  = sign_ch_reg;
        sign_len_next = sign_len_reg;
        pad_next      = pad_reg;
        zero_next     = zero_reg;
        tot_next      = tot_reg;
        out_char_next = out_char_reg;
        last_next     = last_reg;
        if (cmd.load)
        begin
            mag_next  = ext[sdff_pkg::VALUE_W-1] ? (~ext + 64'd1) : ext;
            bcd_next  = '0;
            step_next = '0;
            dc_next   = sdff_pkg::DCNT_W'(sdff_pkg::NDIGITS);
            if (ext[sdff_pkg::VALUE_W-1])
                sign_ch_next = sdff_pkg::CH_MINUS;
            else if (cfg.force_plus)
                sign_ch_next = sdff_pkg::CH_PLUS;
            else
                sign_ch_next = sdff_pkg::CH_SPACE;
            sign_len_next = ext[sdff_pkg::VALUE_W-1] || cfg.force_plus || cfg.space_sign;
        end
        if (cmd.dabble)
        begin
            bcd_next  = {adj[sdff_pkg::BCD_W-2:0], mag_reg[sdff_pkg::VALUE_W-1]};
            mag_next  = {mag_reg[sdff_pkg::VALUE_W-2:0], 1'b0};
            step_next = step_reg + sdff_pkg::STEP_W'(1);
        end
        if (cmd.scan)
        begin
            bcd_next = {bcd_reg[sdff_pkg::BCD_W-5:0], 4'd0};
            dc_next  = dc_reg - sdff_pkg::DCNT_W'(1);
        end
        if (cmd.plan)
        begin
            dc_next   = dc_eff;
            pad_next  = pad7[CW-1:0];
            zero_next = z7[CW-1:0];
            tot_next  = tot7[CW-1:0];
        end
        if (cmd.emit)
        begin
            out_char_next = emit_ch;
            last_next     = (tot_reg == CW'(1));
            tot_next      = tot_reg - CW'(1);
            case (cmd.src)
                sdff_pkg::SRC_SPACE: pad_next  = pad_reg - CW'(1);
                sdff_pkg::SRC_ZERO:  zero_next = zero_reg - CW'(1);
                sdff_pkg::SRC_DIGIT:
                begin
                    bcd_next = {bcd_reg[sdff_pkg::BCD_W-5:0], 4'd0};
                    dc_next  = dc_reg - sdff_pkg::DCNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            dc_reg       <= '0;
            sign_len_reg <= 1'b0;
            pad_reg      <= '0;
            zero_reg     <= '0;
            tot_reg      <= '0;
        end
        else
        begin
            step_reg     <= step_next;
            dc_reg       <= dc_next;
            sign_len_reg <= sign_len_next;
            pad_reg      <= pad_next;
            zero_reg     <= zero_next;
            tot_reg      <= tot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        sign_ch_reg  <= sign_ch_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign sts.conv_last  = (step_reg == '1);
    assign sts.scan_more  = (top_nib == 4'd0) && (dc_reg > sdff_pkg::DCNT_W'(1));
    assign sts.pad_zero   = (pad_reg == '0);
    assign sts.zeros_zero = (zero_reg == '0);
    assign sts.dig_zero   = (dc_reg == '0);
    assign sts.has_sign   = sign_len_reg;
    assign sts.last       = (tot_reg == CW'(1));

    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule

// ===== src/sdff_ctrl.sv =====
// Controller: sequences conversion, digit scan, planning and the character phases.
`include "signed_decimal_field_formatter_macros.svh"

module sdff_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  sdff_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  sdff_pkg::sts_t sts,
    output sdff_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PLAN,
        ST_PADL,
        ST_SIGN,
        ST_ZERO,
        ST_DIGIT,
        ST_PADR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = sdff_pkg::SRC_SPACE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (sts.conv_last)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_more)
                    cmd.scan = 1'b1;
                else
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_PADL;
            end
            ST_PADL:
            begin
                cmd.src = sdff_pkg::SRC_SPACE;
                if (!cfg.left_justify && !sts.pad_zero)
                    cmd.emit = slot_free;
                else
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                cmd.src = sdff_pkg::SRC_SIGN;
                if (sts.has_sign)
                begin
                    cmd.emit = slot_free;
                    if (slot_free)
                        state_next = ST_ZERO;
                end
                else
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.src = sdff_pkg::SRC_ZERO;
                if (!sts.zeros_zero)
                    cmd.emit = slot_free;
                else
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.src = sdff_pkg::SRC_DIGIT;
                if (!sts.dig_zero)
                    cmd.emit = slot_free;
                else
                    state_next = ST_PADR;
            end
            ST_PADR:
            begin
                cmd.src = sdff_pkg::SRC_SPACE;
                if (cfg.left_justify && !sts.pad_zero)
                    cmd.emit = slot_free;
                else
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SDFF_ASSERT_NEXT(a_accept_starts_conv, in_valid && in_ready, state_reg == ST_CONV)
    `SDFF_ASSERT_NEXT(a_conv_ends_in_scan, (state_reg == ST_CONV) && sts.conv_last, state_reg == ST_SCAN)
    `SDFF_ASSERT_NEXT(a_quiet_after_last, cmd.emit && sts.last, !cmd.emit)

endmodule

// ===== src/signed_decimal_field_formatter.sv =====
// Top level of the signed decimal field formatter: config registers, controller, datapath.
//
// Formats one signed 64-bit value per transfer as printf %d text, one ASCII
// character per output transfer, with last_char set on the final character.
// The value is first cut to the width chosen by length_mode (8/16/32/64 bits)
// and sign-extended. The field follows C rules: '-' for negatives, else '+'
// (force_plus, wins over space_sign) or ' ' (space_sign); digits zero-padded to
// the precision (or to the width under zero_pad when no precision is given);
// spaces to field_width on the left, or on the right under left_justify.
// field_width saturates at MAX_FIELD and the precision is capped so that the
// sign and digits fit in MAX_FIELD. A zero value with an explicit precision of
// zero prints no digits and may produce no output transfer at all.
// Per value: the accept, shift-add-3 conversion (one magnitude bit per cycle),
// stripping of leading zero digits (at least one digit is kept), planning,
// then the phases left pad, sign, zeros, digits and right pad; each character
// waits until the single character output register is free. in_ready is high
// only between values; a value may be accepted while the previous last
// character still waits on out_ready.
// Config registers are written through the cfg channel (always ready) and
// must only change while no value is in progress; indexes above 7 are ignored.
module signed_decimal_field_formatter #(
    parameter int MAX_FIELD = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdff_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [sdff_pkg::CDATA_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sdff_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_char,
    output logic                                last_char
);

    sdff_pkg::cfg_t cfg_reg, cfg_next;
    sdff_pkg::cmd_t cmd;
    sdff_pkg::sts_t sts;

    // Accept every config write; drop bits above each register's width.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sdff_pkg::CFG_LENGTH_MODE:
                    cfg_next.length_mode = sdff_pkg::len_t'(cfg_data[1:0]);
                sdff_pkg::CFG_LEFT_JUSTIFY:  cfg_next.left_justify  = cfg_data[0];
                sdff_pkg::CFG_FORCE_PLUS:    cfg_next.force_plus    = cfg_data[0];
                sdff_pkg::CFG_SPACE_SIGN:    cfg_next.space_sign    = cfg_data[0];
                sdff_pkg::CFG_ZERO_PAD:      cfg_next.zero_pad      = cfg_data[0];
                sdff_pkg::CFG_HAS_PRECISION: cfg_next.has_precision = cfg_data[0];
                sdff_pkg::CFG_PRECISION:
                    cfg_next.precision = cfg_data[sdff_pkg::PREC_W-1:0];
                sdff_pkg::CFG_FIELD_WIDTH:
                    cfg_next.field_width = cfg_data[sdff_pkg::FW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                length_mode:   sdff_pkg::LEN_INT,
                left_justify:  1'b0,
                force_plus:    1'b0,
                space_sign:    1'b0,
                zero_pad:      1'b0,
                has_precision: 1'b0,
                precision:     '0,
                field_width:   '0
            };
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the sequence in the controller; move data in the datapath.
    sdff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sdff_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

// ===== test/tb_signed_decimal_field_formatter.sv =====
// Testbench for signed_decimal_field_formatter: random and directed values checked per character.

class sdff_scoreboard;
    localparam int FIELD_LIMIT = 64;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    sdff_pkg::cfg_t regs;
    field_char_t    expected_chars[$];
    int             errors;

    function new();
        regs = '0;
        regs.length_mode = sdff_pkg::LEN_INT;
        errors = 0;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    // Mirror one register write; unknown indexes and excess data bits drop out.
    function void apply_write(logic [sdff_pkg::CIDX_W-1:0] idx,
                              logic [sdff_pkg::CDATA_W-1:0] data);
        case (idx)
            sdff_pkg::CFG_LENGTH_MODE:   regs.length_mode = sdff_pkg::len_t'(data[1:0]);
            sdff_pkg::CFG_LEFT_JUSTIFY:  regs.left_justify = data[0];
            sdff_pkg::CFG_FORCE_PLUS:    regs.force_plus = data[0];
            sdff_pkg::CFG_SPACE_SIGN:    regs.space_sign = data[0];
            sdff_pkg::CFG_ZERO_PAD:      regs.zero_pad = data[0];
            sdff_pkg::CFG_HAS_PRECISION: regs.has_precision = data[0];
            sdff_pkg::CFG_PRECISION:     regs.precision = data[sdff_pkg::PREC_W-1:0];
            sdff_pkg::CFG_FIELD_WIDTH:   regs.field_width = data[sdff_pkg::FW_W-1:0];
            default: ;
        endcase
    endfunction

    // Build the %d text of one accepted value and queue its characters.
    function void format_value(logic [sdff_pkg::VALUE_W-1:0] raw);
        logic [63:0] v;
        logic [63:0] mag;
        logic [3:0]  digits[sdff_pkg::NDIGITS];
        logic [7:0]  sign_ch;
        logic [7:0]  field[$];
        field_char_t fc;
        int          ndig, sign_len, w, p, zeros, body, pad;

        case (regs.length_mode)
            sdff_pkg::LEN_CHAR:  v = {{56{raw[7]}}, raw[7:0]};
            sdff_pkg::LEN_SHORT: v = {{48{raw[15]}}, raw[15:0]};
            sdff_pkg::LEN_INT:   v = {{32{raw[31]}}, raw[31:0]};
            default:             v = raw;
        endcase
        // the most negative value negates onto itself, read as unsigned it is right
        mag = v[63] ? (~v + 64'd1) : v;

        if (v[63])
            sign_ch = sdff_pkg::CH_MINUS;
        else if (regs.force_plus)
            sign_ch = sdff_pkg::CH_PLUS;
        else if (regs.space_sign)
            sign_ch = sdff_pkg::CH_SPACE;
        else
            sign_ch = 8'h00;
        sign_len = (sign_ch != 8'h00) ? 1 : 0;

        w = (regs.field_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(regs.field_width);

        ndig = 0;
        if (!(regs.has_precision && regs.precision == 0 && mag == 64'd0))
        begin
            do
            begin
                digits[ndig] = 4'(mag % 64'd10);
                mag = mag / 64'd10;
                ndig++;
            end
            while (mag != 64'd0 && ndig < sdff_pkg::NDIGITS);
        end

        if (regs.has_precision)
            p = int'(regs.precision);
        else if (regs.zero_pad)
            p = (w > sign_len) ? w - sign_len : 0;
        else
            p = 0;
        if (p > FIELD_LIMIT - sign_len)
            p = FIELD_LIMIT - sign_len;

        zeros = (p > ndig) ? p - ndig : 0;
        body = sign_len + zeros + ndig;
        pad = (w > body) ? w - body : 0;

        if (!regs.left_justify)
            repeat (pad) field.push_back(sdff_pkg::CH_SPACE);
        if (sign_len != 0)
            field.push_back(sign_ch);
        repeat (zeros) field.push_back(sdff_pkg::CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--)
            field.push_back(sdff_pkg::CH_ZERO + 8'(digits[i]));
        if (regs.left_justify)
            repeat (pad) field.push_back(sdff_pkg::CH_SPACE);
        while (field.size() > FIELD_LIMIT)
            void'(field.pop_back());

        foreach (field[i])
        begin
            fc.ch = field[i];
            fc.last = (i == field.size() - 1);
            expected_chars.push_back(fc);
        end
    endfunction

    // Compare one output transfer with the oldest queued character.
    function void check_char(logic [7:0] ch, logic last);
        field_char_t exp_c;
        if (expected_chars.size() == 0)
        begin
            $display("%0t: unexpected char %h last %b, expected none", $time, ch, last);
            errors++;
            return;
        end
        exp_c = expected_chars.pop_front();
        if (ch !== exp_c.ch)
        begin
            $display("%0t: out_char expected %h actual %h", $time, exp_c.ch, ch);
            errors++;
        end
        if (last !== exp_c.last)
        begin
            $display("%0t: last_char expected %b actual %b", $time, exp_c.last, last);
            errors++;
        end
    endfunction
endclass

module tb_signed_decimal_field_formatter;
    // Longest correct stretch without any transfer is the receiver hold-off
    // plus one conversion; the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT     = 5000;
    // Margin that covers one value passing through conversion and planning.
    localparam int SETTLE_CYCLES      = 200;
    localparam int HOLD_CYCLES        = 700;
    localparam int HOLD_AFTER_ITEMS   = 120;
    localparam int RANDOM_ITEMS       = 310;
    localparam int IDLE_PCT           = 20;
    localparam int FIRST_UNUSED_INDEX = 8;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [sdff_pkg::CIDX_W-1:0]         cfg_index;
    logic [sdff_pkg::CDATA_W-1:0]        cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [sdff_pkg::VALUE_W-1:0] value;
    logic                                out_valid;
    logic                                out_ready;
    logic [7:0]                          out_char;
    logic                                last_char;

    sdff_scoreboard sb;
    int in_count = 0;
    int stalled_cycles = 0;
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    bit hold_done = 1'b0;

    signed_decimal_field_formatter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Observe every transfer on the pre-edge values, feed the scoreboard and
    // run the watchdog. Counters advance with nonblocking updates so other
    // processes see them consistently within the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                sb.format_value(value);
                in_count <= in_count + 1;
            end
            if (out_valid && out_ready)
                sb.check_char(out_char, last_char);

            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off once the sender
    // is already waiting, so the block fills up and blocks its input.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && in_count >= HOLD_AFTER_ITEMS && in_valid && !in_ready)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Drop valid, wait for every queued character, then let a value with no
    // output finish its conversion before anything else happens.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [sdff_pkg::CIDX_W-1:0] idx,
                             logic [sdff_pkg::CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load a full setting while idle; junk goes into the unused upper data
    // bits, and one write to an unmapped index must leave everything alone.
    task automatic set_cfg(sdff_pkg::len_t lm, bit lj, bit fp, bit ss, bit zp, bit hp,
                           int prec, int fw);
        logic [7:0] junk;
        drain();
        cfg_write(sdff_pkg::CIDX_W'(FIRST_UNUSED_INDEX + $urandom_range(0, 7)), 8'($urandom));
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_LENGTH_MODE, {junk[7:2], lm});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_LEFT_JUSTIFY, {junk[7:1], lj});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_FORCE_PLUS, {junk[7:1], fp});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_SPACE_SIGN, {junk[7:1], ss});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_ZERO_PAD, {junk[7:1], zp});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_HAS_PRECISION, {junk[7:1], hp});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_PRECISION, {junk[7:6], 6'(prec)});
        junk = 8'($urandom);
        cfg_write(sdff_pkg::CFG_FIELD_WIDTH, {junk[7], 7'(fw)});
    endtask

    // Offer one value; keep valid high across back-to-back transfers.
    task automatic send_value(logic [sdff_pkg::VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Mostly small sizes, a few near or past the saturation point.
    function automatic int pick_size(int small_max, int mid_max, int big_lo, int big_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, small_max);
        else if (r < 90)
            return $urandom_range(small_max + 1, mid_max);
        else
            return $urandom_range(big_lo, big_hi);
    endfunction

    function automatic logic [sdff_pkg::VALUE_W-1:0] random_value();
        logic [63:0] t;
        int          k;
        case ($urandom_range(0, 5))
            0, 1: return {$urandom, $urandom};
            2:
            begin
                t = 64'($urandom_range(0, 40));
                return t - 64'd20;
            end
            3:
            begin
                case ($urandom_range(0, 8))
                    0: return 64'h7F;
                    1: return 64'h80;
                    2: return 64'h7FFF;
                    3: return 64'h8000;
                    4: return 64'h7FFF_FFFF;
                    5: return 64'h8000_0000;
                    6: return 64'h7FFF_FFFF_FFFF_FFFF;
                    7: return 64'h8000_0000_0000_0000;
                    default: return 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            4: return 64'd0;
            default:
            begin
                // powers of ten and their neighbors exercise every digit count
                t = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) t = t * 64'd10;
                case ($urandom_range(0, 3))
                    0: return t;
                    1: return t - 64'd1;
                    2: return -t;
                    default: return -(t - 64'd1);
                endcase
            end
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int n;

        sb = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: 32-bit operand, no flags; upper bits must be ignored.
        send_value(64'd0);
        send_value(64'd1);
        send_value(-64'sd1);
        send_value(64'h7FFF_FFFF);
        send_value(64'h8000_0000);
        send_value(64'hFFFF_FFFF_0000_0005);

        // Plus wins over space; most negative 64-bit value; wide right-aligned field.
        set_cfg(sdff_pkg::LEN_LONG, 0, 1, 1, 0, 0, 0, 25);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'd0);

        // Zero padding with a sign and width zero must not underflow.
        set_cfg(sdff_pkg::LEN_CHAR, 0, 0, 1, 1, 0, 0, 0);
        send_value(64'hABCD_0000_0000_0080);
        send_value(64'h7F);
        send_value(64'd0);

        // Zero value with explicit precision zero and no sign: no characters.
        set_cfg(sdff_pkg::LEN_SHORT, 0, 0, 0, 0, 1, 0, 0);
        send_value(64'd0);
        send_value(64'h8000);
        send_value(64'd5);

        // Oversized width and precision saturate.
        set_cfg(sdff_pkg::LEN_LONG, 0, 1, 0, 0, 1, 63, 127);
        send_value(-64'sd1);
        send_value(64'd12345);

        // Zero flag ignored when a precision is given; left justified.
        set_cfg(sdff_pkg::LEN_INT, 1, 0, 0, 1, 1, 5, 12);
        send_value(-64'sd42);
        send_value(64'd0);

        // Zero padding to the full field width.
        set_cfg(sdff_pkg::LEN_INT, 0, 0, 0, 1, 0, 0, 64);
        send_value(-64'sd7);
        send_value(64'd7);

        // Space sign with no digits, padded on the right.
        set_cfg(sdff_pkg::LEN_CHAR, 1, 0, 1, 0, 1, 0, 3);
        send_value(64'd0);

        // Random phases, each under a fresh setting; a few run with no idling.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_cfg(sdff_pkg::len_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), pick_size(6, 25, 55, 63),
                    pick_size(12, 30, 60, 127));
            if (phase >= 2 && phase <= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            n = $urandom_range(10, 25);
            repeat (n) send_value(random_value());
            sent += n;
            phase++;
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
